>>> rtl/dssfb_pkg.sv
`timescale 1ns / 1ps
// Package for the decimal seven-segment frame builder.
// Holds the request and result structs, bus command codes and the glyph table.
package dssfb_pkg;

	localparam logic [7:0] CMD_MODE  = 8'h40;
	localparam logic [7:0] CMD_ADDR  = 8'hC0;
	localparam logic [7:0] SEG_MINUS = 8'h40;
	localparam logic [7:0] SEG_BLANK = 8'h00;
	localparam logic [7:0] SEG_DOT   = 8'h80;
	localparam logic [2:0] MAX_DIGITS = 3'd4;

	typedef struct packed {
		logic [1:0]         display_select;
		logic signed [15:0] number;
		logic [3:0]         dot_mask;
		logic               leading_zeros;
		logic [2:0]         digit_count;
		logic [1:0]         start_position;
		logic [7:0]         indicator_leds;
	} req_t;

	typedef struct packed {
		logic [1:0] display_select_res;
		logic [7:0] bus_byte;
		logic       start_before;
		logic       stop_after;
		logic       last;
	} rsp_t;

	// Fields that ride along the pipeline unchanged.
	typedef struct packed {
		logic [1:0] sel;
		logic [3:0] dots;
		logic       lz;
		logic [2:0] cnt;
		logic [1:0] pos;
		logic [7:0] leds;
	} side_t;

	function automatic logic [7:0] glyph(input logic [3:0] d);
		logic [7:0] g;
		case (d)
			4'h0: g = 8'h3F;
			4'h1: g = 8'h06;
			4'h2: g = 8'h5B;
			4'h3: g = 8'h4F;
			4'h4: g = 8'h66;
			4'h5: g = 8'h6D;
			4'h6: g = 8'h7D;
			4'h7: g = 8'h07;
			4'h8: g = 8'h7F;
			4'h9: g = 8'h6F;
			4'hA: g = 8'h77;
			4'hB: g = 8'h7C;
			4'hC: g = 8'h39;
			4'hD: g = 8'h5E;
			4'hE: g = 8'h79;
			4'hF: g = 8'h71;
			default: g = 8'h3F;
		endcase
		return g;
	endfunction

endpackage

>>> rtl/decimal_seven_segment_frame_builder.sv
`timescale 1ns / 1ps
// Decimal frame builder: pipelined digit split followed by a byte serializer.
// Depends on dssfb_pkg for the payload structs, command codes and glyph table.
// A request's first byte is valid after stages s1 to s8 and the serializer. One
// bus byte per cycle while out_ready is high; a request is 3 to 7 bytes (3 +
// digit_count, capped at 4). The eight-stage digit pipeline accepts one per
// cycle unless s8 stalls. Reset clears all valid bits; no clearing pass is needed.
module decimal_seven_segment_frame_builder (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  dssfb_pkg::req_t  in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output dssfb_pkg::rsp_t  out_data
);

	logic adv;
	logic take;
	logic last_w;

	dssfb_pkg::side_t side_in;
	logic [15:0] mag_in;
	logic [2:0]  cnt_in;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;
	dssfb_pkg::side_t sd_s1, sd_s2, sd_s3, sd_s4, sd_s5, sd_s6, sd_s7, sd_s8;
	logic neg_s1, neg_s2, neg_s3, neg_s4, neg_s5, neg_s6, neg_s7, neg_s8;
	logic [15:0] mag_s1, mag_s2, mag_s3;
	logic [5:0]  q_s3, q_s4, q_s5, q_s6, q_s7, q_s8;
	logic [9:0]  r_s3, r_s4;
	logic [3:0]  b_s4, b_s5, b_s6, b_s7;
	logic [6:0]  r2_s5, r2_s6;
	logic [8:0]  nd_s5, nd_s6, nd_s7;
	logic [3:0]  c_s6, c_s7;
	logic [3:0]  e_s7;

	logic [31:0] prod1000;
	logic [15:0] rem1000;
	logic [15:0] prod100;
	logic [9:0]  rem100;
	logic [13:0] prod10;
	logic [6:0]  rem10;
	logic [7:0]  seg_w [4];

	logic              sv_q;
	dssfb_pkg::side_t  sd_q;
	logic [7:0]        seg_q [4];
	logic [2:0]        idx_q;
	logic [2:0]        j_w;

	always_comb begin
		cnt_in = (in_data.digit_count > dssfb_pkg::MAX_DIGITS) ? dssfb_pkg::MAX_DIGITS
			: in_data.digit_count;
		side_in.sel  = in_data.display_select;
		side_in.dots = in_data.dot_mask;
		side_in.lz   = in_data.leading_zeros;
		side_in.cnt  = cnt_in;
		side_in.pos  = in_data.start_position;
		side_in.leds = in_data.indicator_leds;
		mag_in = in_data.number[15] ? (16'd0 - $unsigned(in_data.number))
			: $unsigned(in_data.number);
	end

	assign prod1000 = {16'd0, mag_s2} * 32'd33555;
	assign rem1000  = mag_s3 - 16'(q_s3 * 16'd1000);
	assign prod100  = {6'd0, r_s3} * 16'd41;
	assign rem100   = r_s4 - 10'(b_s4 * 10'd100);
	assign prod10   = {7'd0, r2_s5} * 14'd103;
	assign rem10    = r2_s6 - 7'(c_s6 * 7'd10);

	always_comb begin
		logic [8:0] dv [4];
		logic       lead;
		logic       nz;
		logic [7:0] s;
		dv[0] = neg_s8 ? 9'd0 : {3'd0, q_s8};
		dv[1] = neg_s8 ? nd_s7 : {5'd0, b_s7};
		dv[2] = {5'd0, c_s7};
		dv[3] = {5'd0, e_s7};
		lead = 1'b1;
		for (int k = 0; k < 4; k++) begin
			nz = (dv[k] != 9'd0);
			if (nz) begin
				s = dssfb_pkg::glyph(dv[k][3:0]);
				lead = 1'b0;
			end else if (sd_s8.lz || !lead || k == 3) begin
				s = dssfb_pkg::glyph(4'd0);
			end else begin
				s = dssfb_pkg::SEG_BLANK;
			end
			if (sd_s8.dots[2'(3 - k)]) begin
				s = s | dssfb_pkg::SEG_DOT;
			end
			seg_w[k] = s;
		end
		if (neg_s8) begin
			seg_w[0] = dssfb_pkg::SEG_MINUS;
		end
	end

	assign last_w   = (idx_q == sd_q.cnt + 3'd2);
	assign take     = !sv_q || (out_ready && last_w);
	assign adv      = !v_s8 || take;
	assign in_ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sd_s1  <= side_in;
			neg_s1 <= in_data.number[15];
			mag_s1 <= mag_in;

			sd_s2  <= sd_s1;
			neg_s2 <= neg_s1;
			mag_s2 <= mag_s1;

			sd_s3  <= sd_s2;
			neg_s3 <= neg_s2;
			mag_s3 <= mag_s2;
			q_s3   <= prod1000[30:25];

			sd_s4  <= sd_s3;
			neg_s4 <= neg_s3;
			q_s4   <= q_s3;
			r_s3   <= rem1000[9:0];

			sd_s5  <= sd_s4;
			neg_s5 <= neg_s4;
			q_s5   <= q_s4;
			r_s4   <= r_s3;
			b_s4   <= prod100[15:12];

			sd_s6  <= sd_s5;
			neg_s6 <= neg_s5;
			q_s6   <= q_s5;
			b_s5   <= b_s4;
			r2_s5  <= rem100[6:0];
			nd_s5  <= 9'(q_s5 * 9'd10) + {5'd0, b_s4};

			sd_s7  <= sd_s6;
			neg_s7 <= neg_s6;
			q_s7   <= q_s6;
			b_s6   <= b_s5;
			nd_s6  <= nd_s5;
			r2_s6  <= r2_s5;
			c_s6   <= prod10[13:10];

			sd_s8  <= sd_s7;
			neg_s8 <= neg_s7;
			q_s8   <= q_s7;
			b_s7   <= b_s6;
			nd_s7  <= nd_s6;
			c_s7   <= c_s6;
			e_s7   <= rem10[3:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sv_q  <= 1'b0;
			idx_q <= 3'd0;
		end else if (take) begin
			sv_q  <= v_s8;
			idx_q <= 3'd0;
		end else if (out_ready) begin
			idx_q <= idx_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			sd_q  <= sd_s8;
			seg_q <= seg_w;
		end
	end

	assign j_w = idx_q - 3'd2 + (dssfb_pkg::MAX_DIGITS - sd_q.cnt);

	always_comb begin
		out_data.display_select_res = sd_q.sel;
		out_data.start_before = 1'b0;
		out_data.stop_after   = 1'b0;
		out_data.last         = 1'b0;
		if (idx_q == 3'd0) begin
			out_data.bus_byte     = dssfb_pkg::CMD_MODE;
			out_data.start_before = 1'b1;
			out_data.stop_after   = 1'b1;
		end else if (idx_q == 3'd1) begin
			out_data.bus_byte     = dssfb_pkg::CMD_ADDR + {6'd0, sd_q.pos};
			out_data.start_before = 1'b1;
		end else if (last_w) begin
			out_data.bus_byte   = sd_q.leds;
			out_data.stop_after = 1'b1;
			out_data.last       = 1'b1;
		end else begin
			out_data.bus_byte = seg_q[j_w[1:0]];
		end
	end

	assign out_valid = sv_q;

endmodule

>>> dv/frame_byte_checker.sv
`timescale 1ns / 1ps
// Checker for the decimal seven-segment frame builder: predicts the bus bytes of every
// accepted request and compares them with the bytes the block delivers.
// Depends on dssfb_pkg for the request and result structs and the command codes.
module frame_byte_checker (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             in_ready,
	input  dssfb_pkg::req_t  in_data,
	input  logic             out_valid,
	input  logic             out_ready,
	input  dssfb_pkg::rsp_t  out_data,
	output int               mismatches,
	output int               bytes_pending
);

	// Segment codes for 0..F, entry 0 in the low byte.
	localparam logic [127:0] SEGMENT_CODES = {
		8'h71, 8'h79, 8'h5E, 8'h39, 8'h7C, 8'h77, 8'h6F, 8'h7F,
		8'h07, 8'h7D, 8'h6D, 8'h66, 8'h4F, 8'h5B, 8'h06, 8'h3F
	};

	dssfb_pkg::rsp_t expected_bytes[$];
	dssfb_pkg::rsp_t want;
	int   errors = 0;

	task automatic report_mismatch(input string msg);
		errors++;
		$display("%0t: %s", $time, msg);
	endtask

	function automatic dssfb_pkg::rsp_t frame_byte(input logic [1:0] sel,
			input logic [7:0] b, input logic st, input logic sp, input logic lst);
		dssfb_pkg::rsp_t e;
		e.display_select_res = sel;
		e.bus_byte = b;
		e.start_before = st;
		e.stop_after = sp;
		e.last = lst;
		return e;
	endfunction

	function automatic void predict_frame(input dssfb_pkg::req_t r);
		logic [7:0]  seg [4];
		logic [15:0] raw;
		logic [7:0]  s;
		int unsigned mag;
		int unsigned quot;
		int unsigned scale;
		int unsigned first;
		int unsigned cnt;
		int unsigned k;
		bit          blanking;
		raw = r.number;
		blanking = 1'b1;
		cnt = (r.digit_count > dssfb_pkg::MAX_DIGITS) ? 32'(dssfb_pkg::MAX_DIGITS)
			: 32'(r.digit_count);
		if (raw[15]) begin
			mag = (32'h10000 - 32'(raw)) & 32'hFFFF;
			if (mag == 0) begin
				mag = 32'h8000;
			end
			seg[0] = dssfb_pkg::SEG_MINUS;
			first = 1;
		end else begin
			mag = 32'(raw);
			first = 0;
		end
		// Quotients are not reduced mod 10; only their low nibble picks the glyph.
		for (k = first; k < 4; k++) begin
			scale = (k == 0) ? 1000 : (k == 1) ? 100 : (k == 2) ? 10 : 1;
			quot = mag / scale;
			if (quot == 0) begin
				s = (r.leading_zeros || !blanking || k == 3) ? SEGMENT_CODES[7:0]
					: dssfb_pkg::SEG_BLANK;
			end else begin
				s = SEGMENT_CODES[(quot % 16) * 8 +: 8];
				mag = mag - quot * scale;
				blanking = 1'b0;
			end
			if (r.dot_mask[3 - k]) begin
				s = s | dssfb_pkg::SEG_DOT;
			end
			seg[k] = s;
		end
		expected_bytes.push_back(frame_byte(r.display_select, dssfb_pkg::CMD_MODE,
			1'b1, 1'b1, 1'b0));
		expected_bytes.push_back(frame_byte(r.display_select,
			dssfb_pkg::CMD_ADDR + {6'd0, r.start_position}, 1'b1, 1'b0, 1'b0));
		for (k = 4 - cnt; k < 4; k++) begin
			expected_bytes.push_back(frame_byte(r.display_select, seg[k], 1'b0, 1'b0, 1'b0));
		end
		expected_bytes.push_back(frame_byte(r.display_select, r.indicator_leds,
			1'b0, 1'b1, 1'b1));
	endfunction

	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready) begin
			predict_frame(in_data);
		end
		if (arst_n && out_valid && out_ready) begin
			if (expected_bytes.size() == 0) begin
				report_mismatch($sformatf("unexpected byte %h", out_data.bus_byte));
			end else begin
				want = expected_bytes.pop_front();
				if (out_data.display_select_res !== want.display_select_res) begin
					report_mismatch($sformatf("display select %h, expected %h",
						out_data.display_select_res, want.display_select_res));
				end
				if (out_data.bus_byte !== want.bus_byte) begin
					report_mismatch($sformatf("bus byte %h, expected %h",
						out_data.bus_byte, want.bus_byte));
				end
				if (out_data.start_before !== want.start_before) begin
					report_mismatch($sformatf("start flag %b, expected %b on byte %h",
						out_data.start_before, want.start_before, want.bus_byte));
				end
				if (out_data.stop_after !== want.stop_after) begin
					report_mismatch($sformatf("stop flag %b, expected %b on byte %h",
						out_data.stop_after, want.stop_after, want.bus_byte));
				end
				if (out_data.last !== want.last) begin
					report_mismatch($sformatf("last flag %b, expected %b on byte %h",
						out_data.last, want.last, want.bus_byte));
				end
			end
		end
		bytes_pending <= expected_bytes.size();
		mismatches <= errors;
	end

endmodule

>>> dv/tb.sv
`timescale 1ns / 1ps
// Top of the frame builder testbench: clock, reset, request stimulus, output stalls
// and the verdict. Depends on dssfb_pkg, the block and frame_byte_checker.
module tb;

	localparam int RANDOM_REQUESTS = 430;
	localparam int HOLD_AT         = 150;
	localparam int HOLD_CYCLES     = 300;
	localparam int QUIET_FROM      = 260;
	localparam int QUIET_TO        = 340;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	dssfb_pkg::req_t in_data;
	logic out_valid;
	logic out_ready;
	dssfb_pkg::rsp_t out_data;
	int   mismatches;
	int   bytes_pending;
	int   sent_count = 0;
	logic quiet;

	assign quiet = (sent_count >= QUIET_FROM) && (sent_count < QUIET_TO);

	decimal_seven_segment_frame_builder u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	frame_byte_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.in_data       (in_data),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.out_data      (out_data),
		.mismatches    (mismatches),
		.bytes_pending (bytes_pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("decimal_seven_segment_frame_builder: mismatch");
		$finish;
	end

	function automatic dssfb_pkg::req_t make_request(input int sel, input int num,
			input int dots, input int lz, input int cnt, input int pos, input int leds);
		dssfb_pkg::req_t r;
		r.display_select = 2'(sel);
		r.number = 16'(num);
		r.dot_mask = 4'(dots);
		r.leading_zeros = 1'(lz);
		r.digit_count = 3'(cnt);
		r.start_position = 2'(pos);
		r.indicator_leds = 8'(leds);
		return r;
	endfunction

	function automatic dssfb_pkg::req_t random_request();
		dssfb_pkg::req_t r;
		int   num;
		r.display_select = 2'($urandom_range(0, 3));
		r.dot_mask = 4'($urandom_range(0, 15));
		r.leading_zeros = 1'($urandom_range(0, 1));
		r.start_position = 2'($urandom_range(0, 3));
		r.indicator_leds = 8'($urandom_range(0, 255));
		case ($urandom_range(0, 5))
			0: num = $urandom_range(0, 65535);
			1: num = $urandom_range(0, 20);
			2: num = $urandom_range(0, 9999);
			3: num = -$urandom_range(1, 999);
			4: num = $urandom_range(0, 32) * 1000;
			default: num = $urandom_range(0, 1) ? -$urandom_range(9990, 32768) :
				$urandom_range(9990, 32767);
		endcase
		r.number = 16'(num);
		r.digit_count = ($urandom_range(0, 9) < 8) ? 3'($urandom_range(0, 4)) :
			3'($urandom_range(5, 7));
		return r;
	endfunction

	task automatic send_request(input dssfb_pkg::req_t r);
		while (!quiet && $urandom_range(0, 99) < 11) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= r;
		do @(posedge clk); while (!in_ready);
		sent_count <= sent_count + 1;
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (bytes_pending != 0) begin
			@(posedge clk);
		end
	endtask

	// Output side: random stalls, one long hold-off that backs up the block, and a
	// stretch with no stalls at all.
	initial begin
		bit held;
		int hold_left;
		held = 1'b0;
		hold_left = 0;
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (!held && sent_count >= HOLD_AT) begin
				held = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= quiet || ($urandom_range(0, 99) >= 11);
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_request(make_request(0, 0, 0, 0, 4, 0, 8'h00));
		send_request(make_request(1, 0, 15, 1, 4, 1, 8'hFF));
		send_request(make_request(2, 32767, 0, 0, 4, 2, 8'hA5));
		send_request(make_request(3, -32767, 15, 0, 4, 3, 8'h5A));
		send_request(make_request(0, -32768, 0, 1, 4, 0, 8'h01));
		send_request(make_request(1, 1000, 0, 0, 4, 0, 8'h80));
		send_request(make_request(2, 16000, 0, 0, 4, 0, 8'h00));
		send_request(make_request(3, 5, 4'b0010, 0, 4, 0, 8'h00));
		send_request(make_request(0, -5, 4'b1001, 0, 4, 1, 8'h00));
		send_request(make_request(1, -1, 0, 1, 4, 2, 8'h00));
		send_request(make_request(2, 1234, 0, 0, 0, 3, 8'hFF));
		send_request(make_request(3, 1234, 0, 0, 1, 0, 8'h00));
		send_request(make_request(0, 1234, 0, 0, 2, 0, 8'h00));
		send_request(make_request(1, 1234, 0, 0, 3, 0, 8'h00));
		send_request(make_request(2, 1234, 15, 0, 5, 0, 8'h00));
		send_request(make_request(3, -999, 0, 0, 6, 1, 8'h00));
		send_request(make_request(0, 9999, 0, 0, 7, 2, 8'h00));
		send_request(make_request(1, 99, 0, 1, 4, 3, 8'h00));
		send_request(make_request(2, -100, 0, 0, 4, 0, 8'h3C));
		send_request(make_request(3, 10, 4'b0100, 0, 4, 1, 8'hC3));
		send_request(make_request(0, -10000, 0, 0, 4, 2, 8'h00));
		wait_drained();

		for (int i = 0; i < RANDOM_REQUESTS; i++) begin
			if (i == 100) begin
				wait_drained();
			end
			send_request(random_request());
		end
		wait_drained();
		repeat (20) @(posedge clk);

		if (mismatches == 0) begin
			$display("decimal_seven_segment_frame_builder: match");
		end else begin
			$display("decimal_seven_segment_frame_builder: mismatch");
		end
		$finish;
	end

endmodule
